[hdl/dhk_pkg.sv]
// dhk_pkg: shared types and constants for the modular exponentiation block.
// No dependencies.
`default_nettype none
package dhk_pkg;

  localparam int unsigned MOD_BITS_DEF = 32;
  localparam int unsigned EXP_BITS_DEF = 32;
  localparam int unsigned REG_W        = 32;
  localparam int unsigned CFG_AW       = 3;

  localparam logic [0:0] REG_MODULUS   = 1'b0;
  localparam logic [0:0] REG_GENERATOR = 1'b1;

  localparam logic [REG_W-1:0] MODULUS_RST   = 32'd23;
  localparam logic [REG_W-1:0] GENERATOR_RST = 32'd2;

  localparam int unsigned FALLBACK_PRIMES [6] = '{23, 47, 97, 199, 307, 521};
  localparam int unsigned FALLBACK_GENS   [4] = '{2, 3, 5, 7};

  typedef struct packed {
    logic [REG_W-1:0] modulus;
    logic [REG_W-1:0] generator;
  } dhk_cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_RED_W,
    S_LOAD,
    S_BIT,
    S_MUL_W,
    S_SQ_W,
    S_STORE
  } dhk_state_t;

endpackage : dhk_pkg
`default_nettype wire

[hdl/dhk_modmul.sv]
// dhk_modmul: bit-serial interleaved modular multiplier, one multiplier bit per cycle.
// Depends on nothing but its parameters; requires y < p and p > 1.
`default_nettype none
module dhk_modmul #(
  parameter int unsigned MB = 32,
  parameter int unsigned XB = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [XB-1:0] x,
  input  wire logic [MB-1:0] y,
  input  wire logic [MB-1:0] p,
  output logic               done,
  output logic [MB-1:0]      prod
);

  localparam int unsigned CW = (XB > 1) ? $clog2(XB) : 1;

  logic [MB-1:0] acc_r, acc_nxt;
  logic [XB-1:0] x_r;
  logic [MB-1:0] y_r;
  logic [MB-1:0] p_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [MB:0] dbl, red1, sum, red2;

  always_comb begin
    dbl  = {acc_r, 1'b0};
    red1 = (dbl >= {1'b0, p_r}) ? dbl - {1'b0, p_r} : dbl;
    sum  = red1 + (x_r[XB-1] ? {1'b0, y_r} : '0);
    red2 = (sum >= {1'b0, p_r}) ? sum - {1'b0, p_r} : sum;
    acc_nxt = red2[MB-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(XB - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      x_r   <= x;
      y_r   <= y;
      p_r   <= p;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      x_r   <= x_r << 1;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule : dhk_modmul
`default_nettype wire

[hdl/dhk_cfg.sv]
// dhk_cfg: APB-style register file holding modulus and generator.
// Depends on dhk_pkg.
`default_nettype none
module dhk_cfg
  import dhk_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [REG_W-1:0]  pwdata,
  output logic      [REG_W-1:0]  prdata,
  output logic                   pready,
  output dhk_cfg_t               cfg
);

  dhk_cfg_t   cfg_r;
  logic [0:0] idx;

  assign idx    = paddr[2:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.modulus   <= MODULUS_RST;
      cfg_r.generator <= GENERATOR_RST;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_MODULUS:   cfg_r.modulus   <= pwdata;
        REG_GENERATOR: cfg_r.generator <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODULUS:   prdata = cfg_r.modulus;
      REG_GENERATOR: prdata = cfg_r.generator;
      default:       prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule : dhk_cfg
`default_nettype wire

[hdl/dh_key_exchange_modexp.sv]
// dh_key_exchange_modexp: public keys and shared secrets by square-and-multiply.
// Depends on dhk_pkg, dhk_cfg, dhk_modmul. One shared bit-serial multiplier.
// Up to 2*EXP_BITS-1 modular multiplications per exponentiation, and four exponentiations per run.
// busy drops in the strobe cycle, where the next start is taken; strobe lasts one cycle, no stall.
// Reset: modulus 23, generator 2, sequencer idle.
`default_nettype none
module dh_key_exchange_modexp
  import dhk_pkg::*;
#(
  parameter int unsigned MOD_BITS = MOD_BITS_DEF,
  parameter int unsigned EXP_BITS = EXP_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [REG_W-1:0]  in_secret_a,
  input  wire logic [REG_W-1:0]  in_secret_b,
  output logic                   out_valid,
  output logic [REG_W-1:0]       out_public_key_a,
  output logic [REG_W-1:0]       out_public_key_b,
  output logic [REG_W-1:0]       out_shared_seen_by_a,
  output logic [REG_W-1:0]       out_shared_seen_by_b,
  output logic                   out_used_fallback,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [REG_W-1:0]  pwdata,
  output logic      [REG_W-1:0]  prdata,
  output logic                   pready
);

  dhk_cfg_t cfg;

  dhk_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dhk_state_t state_r, state_nxt;

  logic [MOD_BITS-1:0] p_r, gr_r, acc_r, sq_r;
  logic [MOD_BITS-1:0] pa_r, pb_r, sa_r, sb_r;
  logic [REG_W-1:0]    g_r;
  logic [EXP_BITS-1:0] ea_r, eb_r, e_r;
  logic [1:0]          ph_r;
  logic                fb_r;
  logic                out_valid_r;

  logic [MOD_BITS-1:0] p_eff;
  logic                fb_now;
  logic                accept;

  logic                mm_start, mm_done;
  logic [REG_W-1:0]    mm_x;
  logic [MOD_BITS-1:0] mm_y, mm_prod;
  logic [MOD_BITS-1:0] base_sel;
  logic [EXP_BITS-1:0] exp_sel;
  logic                e_rest_zero;

  assign accept      = start && (state_r == S_IDLE);
  assign p_eff       = cfg.modulus[MOD_BITS-1:0];
  assign fb_now      = (p_eff <= MOD_BITS'(1)) || (cfg.generator == '0);
  assign e_rest_zero = ((e_r >> 1) == '0);

  always_comb begin
    case (ph_r)
      2'd0, 2'd1: base_sel = gr_r;
      2'd2:       base_sel = pb_r;
      default:    base_sel = pa_r;
    endcase
    exp_sel = ph_r[0] ? eb_r : ea_r;
  end

  dhk_modmul #(
    .MB (MOD_BITS),
    .XB (REG_W)
  ) u_mm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mm_start),
    .x     (mm_x),
    .y     (mm_y),
    .p     (p_r),
    .done  (mm_done),
    .prod  (mm_prod)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_RED;
      S_RED:   state_nxt = S_RED_W;
      S_RED_W: if (mm_done) state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_BIT;
      S_BIT: begin
        if (e_r == '0) begin
          state_nxt = S_STORE;
        end else if (e_r[0]) begin
          state_nxt = S_MUL_W;
        end else begin
          state_nxt = S_SQ_W;
        end
      end
      S_MUL_W: begin
        if (mm_done) state_nxt = e_rest_zero ? S_STORE : S_SQ_W;
      end
      S_SQ_W:  if (mm_done) state_nxt = S_BIT;
      S_STORE: state_nxt = (ph_r == 2'd3) ? S_IDLE : S_LOAD;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy     = (state_r != S_IDLE);
    mm_start = 1'b0;
    mm_x     = REG_W'(sq_r);
    mm_y     = sq_r;
    case (state_r)
      S_RED: begin
        mm_start = 1'b1;
        mm_x     = g_r;
        mm_y     = MOD_BITS'(1);
      end
      S_BIT: begin
        mm_start = (e_r != '0);
        if (e_r[0]) mm_x = REG_W'(acc_r);
      end
      S_MUL_W: mm_start = mm_done && !e_rest_zero;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ph_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_STORE) && (ph_r == 2'd3);
      if (accept) begin
        ph_r <= '0;
      end else if (state_r == S_STORE) begin
        ph_r <= ph_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ea_r <= EXP_BITS'(in_secret_a);
      eb_r <= EXP_BITS'(in_secret_b);
      fb_r <= fb_now;
      p_r  <= fb_now ? MOD_BITS'(FALLBACK_PRIMES[0]) : p_eff;
      g_r  <= fb_now ? REG_W'(FALLBACK_GENS[0]) : cfg.generator;
    end
    if (state_r == S_RED_W && mm_done) gr_r <= mm_prod;
    if (state_r == S_LOAD) begin
      acc_r <= MOD_BITS'(1);
      sq_r  <= base_sel;
      e_r   <= exp_sel;
    end
    if (state_r == S_MUL_W && mm_done) acc_r <= mm_prod;
    if (state_r == S_SQ_W && mm_done) begin
      sq_r <= mm_prod;
      e_r  <= e_r >> 1;
    end
    if (state_r == S_STORE) begin
      case (ph_r)
        2'd0:    pa_r <= acc_r;
        2'd1:    pb_r <= acc_r;
        2'd2:    sa_r <= acc_r;
        default: sb_r <= acc_r;
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_public_key_a     = REG_W'(pa_r);
  assign out_public_key_b     = REG_W'(pb_r);
  assign out_shared_seen_by_a = REG_W'(sa_r);
  assign out_shared_seen_by_b = REG_W'(sb_r);
  assign out_used_fallback    = fb_r;

endmodule : dh_key_exchange_modexp
`default_nettype wire
